### hw/rtl/bthp_pkg.sv
// Shared types and constants of the BER TLV header parser.
package bthp_pkg;

	// Default upper limit on long-form length bytes
	localparam int DEF_MAX_FIELD_BYTES = 4;

	// Identifier bytes that fit in the packed tag
	localparam int TAG_MAX_BYTES = 4;

	// Low five identifier bits all set: long-form tag follows
	localparam logic [4:0] TAG_LONG_FORM = 5'h1f;

	// Length byte that opens an indefinite length
	localparam logic [7:0] LEN_INDEFINITE = 8'h80;

	// Count of long-form length bytes in a length octet
	localparam logic [7:0] LEN_COUNT_MASK = 8'h7f;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_TAG  = 2'd1,
		PH_LEN  = 2'd2,
		PH_LONG = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_INDEF    = 3'd1,
		ST_TAG_LONG = 3'd2,
		ST_LEN_LONG = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	// One accepted input byte
	typedef struct packed {
		logic [7:0] byte_in;
		logic       start_header;
	} in_item_t;

	// One decoded header
	typedef struct packed {
		status_t     status;
		logic [31:0] tag_value;
		logic [31:0] content_length;
		logic [3:0]  header_bytes;
		logic [31:0] total_length;
	} result_t;

endpackage

### hw/rtl/ber_tlv_header_parser.sv
// Top level of the BER TLV header parser.
//
// Bytes of a BER encoded element enter on the input channel (byte_in,
// start_header, in_valid/in_ready), one per transaction. The parser decodes
// the identifier (short or long form, up to four bytes packed first byte
// high) and the length (short, indefinite or long form of up to
// MAX_FIELD_BYTES bytes) and gives one result per header on the output
// channel (status, tag_value, content_length, header_bytes, total_length,
// out_valid/out_ready). Bytes that do not finish a header give no result.
// start_header set on a byte drops any partial header.
// Throughput is one byte per cycle unless the receiver stalls. A byte is
// registered on acceptance, decoded against the parse state once the result
// register is free or draining, and its result is registered.
// When the receiver stalls, the result register holds, the input register
// fills and in_ready drops; no byte is lost.
// Reset clears both valid flags and returns the parser to waiting for the
// first identifier byte.
module ber_tlv_header_parser #(
	parameter int MAX_FIELD_BYTES = bthp_pkg::DEF_MAX_FIELD_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        byte_in,
	input  logic              start_header,
	output logic              out_valid,
	input  logic              out_ready,
	output bthp_pkg::status_t status,
	output logic [31:0]       tag_value,
	output logic [31:0]       content_length,
	output logic [3:0]        header_bytes,
	output logic [31:0]       total_length
);
	import bthp_pkg::*;

	in_item_t in_item;
	in_item_t item_s1;
	logic     valid_s1;
	logic     advance;
	logic     res_valid;
	result_t  res;
	result_t  out_res;

	assign in_item.byte_in      = byte_in;
	assign in_item.start_header = start_header;

	// Process the held byte once the result slot is free or draining
	assign advance = valid_s1 && (!out_valid || out_ready);

	bthp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	bthp_decoder #(
		.MAX_FIELD_BYTES (MAX_FIELD_BYTES)
	) u_decoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item_s1   (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	bthp_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign status         = out_res.status;
	assign tag_value      = out_res.tag_value;
	assign content_length = out_res.content_length;
	assign header_bytes   = out_res.header_bytes;
	assign total_length   = out_res.total_length;

endmodule

### hw/rtl/bthp_in_stage.sv
// Input register of the BER TLV header parser.
module bthp_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bthp_pkg::in_item_t in_item,
	input  logic              advance,
	output logic              valid_s1,
	output bthp_pkg::in_item_t item_s1
);
	import bthp_pkg::*;

	// Take a new transaction when empty or when the held one moves on
	assign in_ready = !valid_s1 || advance;

	// Hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

### hw/rtl/bthp_decoder.sv
// Header parse state and per-byte decode logic of the BER TLV header parser.
module bthp_decoder #(
	parameter int MAX_FIELD_BYTES = bthp_pkg::DEF_MAX_FIELD_BYTES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  bthp_pkg::in_item_t item_s1,
	output logic               res_valid,
	output bthp_pkg::result_t  res
);
	import bthp_pkg::*;

	localparam int LW = $clog2(MAX_FIELD_BYTES + 1);

	phase_t      phase_q, phase_n, phase_eff;
	logic [31:0] tag_q, tag_n;
	logic [2:0]  tag_cnt_q, tag_cnt_n;
	logic [31:0] len_q, len_n;
	logic [LW-1:0] left_q, left_n;
	logic [3:0]  hdr_q, hdr_n;
	logic        wide_q, wide_n;

	logic        emit;
	status_t     emit_status;
	logic [31:0] emit_content;
	logic [31:0] emit_total;
	logic        fin;
	logic [31:0] fin_content;
	logic [32:0] fin_sum;
	logic [7:0]  b;

	assign b = item_s1.byte_in;

	// Advance the parse state on each processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			tag_q     <= '0;
			tag_cnt_q <= '0;
			len_q     <= '0;
			left_q    <= '0;
			hdr_q     <= '0;
			wide_q    <= 1'b0;
		end else if (advance) begin
			phase_q   <= phase_n;
			tag_q     <= tag_n;
			tag_cnt_q <= tag_cnt_n;
			len_q     <= len_n;
			left_q    <= left_n;
			hdr_q     <= hdr_n;
			wide_q    <= wide_n;
		end
	end

	// Decode one byte: next state and any finished header
	always_comb begin
		phase_eff    = item_s1.start_header ? PH_IDLE : phase_q;
		phase_n      = phase_q;
		tag_n        = tag_q;
		tag_cnt_n    = tag_cnt_q;
		len_n        = len_q;
		left_n       = left_q;
		hdr_n        = hdr_q;
		wide_n       = wide_q;
		emit         = 1'b0;
		emit_status  = ST_OK;
		emit_content = '0;
		emit_total   = '0;
		fin          = 1'b0;
		fin_content  = '0;

		case (phase_eff)
			PH_IDLE: begin
				tag_n     = {b, 24'h0};
				tag_cnt_n = 3'd1;
				hdr_n     = 4'd1;
				len_n     = '0;
				left_n    = '0;
				wide_n    = 1'b0;
				phase_n   = (b[4:0] == TAG_LONG_FORM) ? PH_TAG : PH_LEN;
			end
			PH_TAG: begin
				case (tag_cnt_q)
					3'd1: tag_n[23:16] = tag_q[23:16] | b;
					3'd2: tag_n[15:8]  = tag_q[15:8] | b;
					3'd3: tag_n[7:0]   = tag_q[7:0] | b;
					default: tag_n = tag_q;
				endcase
				tag_cnt_n = tag_cnt_q + 3'd1;
				hdr_n     = hdr_q + 4'd1;
				if (!b[7]) begin
					phase_n = PH_LEN;
				end else if (tag_cnt_n >= 3'(TAG_MAX_BYTES)) begin
					emit        = 1'b1;
					emit_status = ST_TAG_LONG;
				end
			end
			PH_LEN: begin
				hdr_n = hdr_q + 4'd1;
				if (!b[7]) begin
					fin         = 1'b1;
					fin_content = {24'h0, b};
				end else if (b == LEN_INDEFINITE) begin
					emit        = 1'b1;
					emit_status = ST_INDEF;
					emit_total  = {28'h0, hdr_n};
				end else if ((b & LEN_COUNT_MASK) > 8'(MAX_FIELD_BYTES)) begin
					emit        = 1'b1;
					emit_status = ST_LEN_LONG;
				end else begin
					len_n   = '0;
					left_n  = b[LW-1:0];
					wide_n  = 1'b0;
					phase_n = PH_LONG;
				end
			end
			PH_LONG: begin
				hdr_n  = hdr_q + 4'd1;
				wide_n = wide_q || (len_q[31:24] != 8'h0);
				len_n  = {len_q[23:0], b};
				if (left_q != '0) begin
					left_n = left_q - LW'(1);
				end
				if (left_n == '0) begin
					if (wide_n) begin
						emit        = 1'b1;
						emit_status = ST_LEN_LONG;
					end else begin
						fin         = 1'b1;
						fin_content = len_n;
					end
				end
			end
			default: begin
				phase_n = PH_IDLE;
			end
		endcase

		// Add header bytes to the content length, saturate on carry
		fin_sum = {1'b0, fin_content} + {29'h0, hdr_n};
		if (fin) begin
			emit         = 1'b1;
			emit_content = fin_content;
			if (fin_sum[32]) begin
				emit_status = ST_OVERFLOW;
				emit_total  = '1;
			end else begin
				emit_status = ST_OK;
				emit_total  = fin_sum[31:0];
			end
		end

		// A finished header returns the parser to idle
		if (emit) begin
			phase_n = PH_IDLE;
		end
	end

	assign res_valid          = advance && emit;
	assign res.status         = emit_status;
	assign res.tag_value      = tag_n;
	assign res.content_length = emit_content;
	assign res.header_bytes   = hdr_n;
	assign res.total_length   = emit_total;

endmodule

### hw/rtl/bthp_out_stage.sv
// Result register of the BER TLV header parser.
module bthp_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	input  bthp_pkg::result_t res,
	output logic              out_valid,
	input  logic              out_ready,
	output bthp_pkg::result_t out_res
);
	import bthp_pkg::*;

	// Hold the valid flag until the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_valid) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Load a fresh result
	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_res <= res;
		end
	end

endmodule

### hw/rtl/bthp_checker.sv
// Port-level checker of the BER TLV header parser, with its bind.
module bthp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input bthp_pkg::status_t status,
	input logic [31:0]       tag_value,
	input logic [31:0]       content_length,
	input logic [3:0]        header_bytes,
	input logic [31:0]       total_length
);
	import bthp_pkg::*;

	// A good header totals content plus header bytes
	a_ok_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |->
			total_length == content_length + {28'h0, header_bytes})
		else $error("ok result with wrong total length");

	// Tag or length errors carry no lengths
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_TAG_LONG || status == ST_LEN_LONG) |->
			content_length == 32'h0 && total_length == 32'h0)
		else $error("error result with non-zero length");

	// Indefinite length totals the header alone
	a_indef: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_INDEF |->
			content_length == 32'h0 && total_length == {28'h0, header_bytes})
		else $error("indefinite result with wrong lengths");

	// Overflow saturates and every header has at least two bytes
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> header_bytes >= 4'd2 &&
			(status != ST_OVERFLOW || total_length == 32'hffff_ffff))
		else $error("short header or unsaturated overflow");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tag_value) &&
			$stable(total_length))
		else $error("result dropped or changed while stalled");

endmodule

bind ber_tlv_header_parser bthp_checker u_bthp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.status         (status),
	.tag_value      (tag_value),
	.content_length (content_length),
	.header_bytes   (header_bytes),
	.total_length   (total_length)
);

### test/ber_tlv_header_parser_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the BER TLV header parser with a built-in header decoder.
module ber_tlv_header_parser_tb;
	import bthp_pkg::*;

	localparam int MAX_LEN_BYTES = DEF_MAX_FIELD_BYTES;
	localparam int RANDOM_BYTES  = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 400000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  byte_in;
	logic        start_header;
	logic        out_valid;
	logic        out_ready;
	status_t     status;
	logic [31:0] tag_value;
	logic [31:0] content_length;
	logic [3:0]  header_bytes;
	logic [31:0] total_length;

	ber_tlv_header_parser #(
		.MAX_FIELD_BYTES(MAX_LEN_BYTES)
	) DUT (
		.clk,
		.arst_n,
		.in_valid,
		.in_ready,
		.byte_in,
		.start_header,
		.out_valid,
		.out_ready,
		.status,
		.tag_value,
		.content_length,
		.header_bytes,
		.total_length
	);

	// Decoder state of the testbench
	phase_t      dec_phase;
	logic [31:0] dec_tag;
	int          dec_tag_cnt;
	logic [31:0] dec_len;
	int          dec_len_left;
	int          dec_hdr_cnt;
	logic        dec_len_wide;

	result_t     pending_hdrs[$];
	logic [7:0]  hdr_bytes[$];
	int unsigned bytes_sent;
	int unsigned mismatches;
	logic        calm;
	logic        last_cut;

	// Generate the clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Abort a hung run
	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("end of test: mismatches");
		$finish;
	end

	// Gap length: mostly none or short, now and then long
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void clear_decoder();
		dec_phase    = PH_IDLE;
		dec_tag      = '0;
		dec_tag_cnt  = 0;
		dec_len      = '0;
		dec_len_left = 0;
		dec_hdr_cnt  = 0;
		dec_len_wide = 1'b0;
	endfunction

	// Queue a finished header and return to waiting
	function automatic void close_header(input status_t st, input logic [31:0] content,
			input logic [31:0] total);
		result_t r;
		r.status         = st;
		r.tag_value      = dec_tag;
		r.content_length = content;
		r.header_bytes   = 4'(dec_hdr_cnt);
		r.total_length   = total;
		pending_hdrs.push_back(r);
		clear_decoder();
	endfunction

	// Add the header size to the content length, saturating on overflow
	function automatic void finish_length(input logic [31:0] content);
		logic [32:0] sum;
		sum = {1'b0, content} + 33'(dec_hdr_cnt);
		if (sum[32])
			close_header(ST_OVERFLOW, content, 32'hFFFF_FFFF);
		else
			close_header(ST_OK, content, sum[31:0]);
	endfunction

	// Advance the decoder by one accepted byte
	function automatic void decode_byte(input logic [7:0] b, input logic sh);
		if (sh)
			clear_decoder();
		case (dec_phase)
			PH_IDLE: begin
				clear_decoder();
				dec_tag     = {b, 24'h0};
				dec_tag_cnt = 1;
				dec_hdr_cnt = 1;
				dec_phase   = (b[4:0] == TAG_LONG_FORM) ? PH_TAG : PH_LEN;
			end
			PH_TAG: begin
				if (dec_tag_cnt >= 1 && dec_tag_cnt <= 3)
					dec_tag |= {24'h0, b} << ((3 - dec_tag_cnt) * 8);
				dec_tag_cnt++;
				dec_hdr_cnt++;
				if (!b[7])
					dec_phase = PH_LEN;
				else if (dec_tag_cnt >= TAG_MAX_BYTES)
					close_header(ST_TAG_LONG, '0, '0);
			end
			PH_LEN: begin
				dec_hdr_cnt++;
				if (b < LEN_INDEFINITE)
					finish_length({24'h0, b});
				else if (b == LEN_INDEFINITE)
					close_header(ST_INDEF, '0, 32'(dec_hdr_cnt));
				else if (int'(b & LEN_COUNT_MASK) > MAX_LEN_BYTES)
					close_header(ST_LEN_LONG, '0, '0);
				else begin
					dec_len      = '0;
					dec_len_left = int'(b & LEN_COUNT_MASK);
					dec_len_wide = 1'b0;
					dec_phase    = PH_LONG;
				end
			end
			default: begin
				dec_hdr_cnt++;
				if (dec_len[31:24] != 8'h0)
					dec_len_wide = 1'b1;
				dec_len = {dec_len[23:0], b};
				if (dec_len_left > 0)
					dec_len_left--;
				if (dec_len_left == 0) begin
					if (dec_len_wide)
						close_header(ST_LEN_LONG, '0, '0);
					else
						finish_length(dec_len);
				end
			end
		endcase
	endfunction

	// Send one byte as a transaction and predict its effect on acceptance
	task automatic send_byte(input logic [7:0] b, input logic sh);
		int unsigned gap;
		gap = calm ? 0 : gap_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		byte_in      <= b;
		start_header <= sh;
		do
			@(posedge clk);
		while (!in_ready);
		bytes_sent++;
		decode_byte(b, sh);
	endtask

	// Send the staged header bytes, start flag on the first only
	task automatic send_header(input logic first_start);
		foreach (hdr_bytes[i])
			send_byte(hdr_bytes[i], (i == 0) ? first_start : 1'b0);
		hdr_bytes.delete();
	endtask

	// Hold the sender until every predicted header has come out
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_hdrs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Short identifiers with short lengths, with and without start flag
	task automatic test_short_headers();
		hdr_bytes = '{8'h00, 8'h00};
		send_header(1'b1);
		hdr_bytes = '{8'h1E, 8'h7F};
		send_header(1'b0);
		wait_for_results();
	endtask

	// Long-form identifiers: full four bytes, and one byte too many
	task automatic test_long_tags();
		hdr_bytes = '{8'h1F, 8'hFF, 8'hFF, 8'h7F, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hF6};
		send_header(1'b1);
		hdr_bytes = '{8'h3F, 8'h80, 8'h80, 8'h80};
		send_header(1'b0);
		wait_for_results();
	endtask

	// Indefinite, long form with overflow, count too big and the reserved count
	task automatic test_length_forms();
		hdr_bytes = '{8'h20, LEN_INDEFINITE};
		send_header(1'b1);
		hdr_bytes = '{8'hC1, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFA};
		send_header(1'b0);
		hdr_bytes = '{8'h21, 8'(129 + MAX_LEN_BYTES)};
		send_header(1'b1);
		hdr_bytes = '{8'h22, 8'hFF};
		send_header(1'b0);
		wait_for_results();
	endtask

	// Drop partial headers with the start flag
	task automatic test_restart();
		hdr_bytes = '{8'h30, 8'h81};
		send_header(1'b1);
		hdr_bytes = '{8'h02, 8'h01};
		send_header(1'b1);
		hdr_bytes = '{8'h1F, 8'h81};
		send_header(1'b0);
		hdr_bytes = '{8'h40, 8'h00};
		send_header(1'b1);
		wait_for_results();
	endtask

	// Stage a random header, well-formed or with a too-long identifier or too big a length count
	task automatic build_random_header();
		int unsigned tag_kind;
		int unsigned len_kind;
		int unsigned n;
		logic [7:0]  b;
		tag_kind = $urandom_range(0, 9);
		if (tag_kind < 5) begin
			do
				b = 8'($urandom);
			while (b[4:0] == TAG_LONG_FORM);
			hdr_bytes.push_back(b);
		end else begin
			b = 8'($urandom);
			b[4:0] = TAG_LONG_FORM;
			hdr_bytes.push_back(b);
			n = (tag_kind == 9) ? TAG_MAX_BYTES - 1 : $urandom_range(1, TAG_MAX_BYTES - 1);
			for (int i = 0; i < n; i++) begin
				b = 8'($urandom);
				b[7] = (tag_kind == 9) || (i != n - 1);
				hdr_bytes.push_back(b);
			end
		end
		// a too-long identifier ends the header on its own
		if (tag_kind == 9)
			return;
		len_kind = $urandom_range(0, 9);
		if (len_kind < 4)
			hdr_bytes.push_back(8'($urandom_range(0, 127)));
		else if (len_kind == 4)
			hdr_bytes.push_back(LEN_INDEFINITE);
		else if (len_kind == 5)
			hdr_bytes.push_back(8'($urandom_range(129 + MAX_LEN_BYTES, 255)));
		else begin
			// near-maximum values reach the overflow boundary
			n = (len_kind == 9) ? MAX_LEN_BYTES : $urandom_range(1, MAX_LEN_BYTES);
			hdr_bytes.push_back(8'(128 + n));
			for (int i = 0; i < n; i++)
				hdr_bytes.push_back((len_kind == 9) ?
					((i < n - 1) ? 8'hFF : 8'($urandom_range(240, 255))) : 8'($urandom));
		end
	endtask

	// Mostly well-formed headers, some cut short, some noise bytes
	task automatic test_random_stream();
		int unsigned target;
		logic        first_start;
		logic        paused;
		target = bytes_sent + RANDOM_BYTES;
		paused = 1'b0;
		last_cut = 1'b0;
		while (bytes_sent < target) begin
			calm = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 3))
					send_byte(8'($urandom), 1'($urandom));
				last_cut = 1'b1;
			end else begin
				build_random_header();
				first_start = last_cut ? ($urandom_range(0, 3) != 0) : 1'($urandom);
				last_cut = ($urandom_range(0, 7) == 0);
				if (last_cut)
					repeat ($urandom_range(1, hdr_bytes.size() - 1))
						void'(hdr_bytes.pop_back());
				send_header(first_start);
			end
			if (!paused && bytes_sent + RANDOM_BYTES / 2 >= target) begin
				wait_for_results();
				paused = 1'b1;
			end
		end
		calm = 1'b0;
	endtask

	// Drive the receiver: ready bursts and stalls of random length
	initial begin : sink_side
		int unsigned left;
		left = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (left != 0)
				left--;
			else if (out_ready && !calm) begin
				out_ready <= 1'b0;
				left = gap_len();
			end else begin
				out_ready <= 1'b1;
				left = $urandom_range(0, 15);
			end
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Compare each output transaction with the oldest predicted header
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_hdrs.size() == 0) begin
				$display("%0t: unexpected result expected none got %h %h %h %h %h", $time,
					status, tag_value, content_length, header_bytes, total_length);
				mismatches++;
			end else begin
				want = pending_hdrs.pop_front();
				check_field("status", 32'(want.status), 32'(status));
				check_field("tag_value", want.tag_value, tag_value);
				check_field("content_length", want.content_length, content_length);
				check_field("header_bytes", 32'(want.header_bytes), 32'(header_bytes));
				check_field("total_length", want.total_length, total_length);
			end
		end
	end

	// Run the tests in turn
	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		byte_in      = 8'h00;
		start_header = 1'b0;
		calm         = 1'b0;
		last_cut     = 1'b0;
		bytes_sent   = 0;
		mismatches   = 0;
		clear_decoder();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_headers();
		test_long_tags();
		test_length_forms();
		test_restart();
		test_random_stream();

		wait_for_results();
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
